[hdl/brb_pkg.sv]
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the circular byte buffer: item codes,
// status codes and the controller to datapath command and status groups.
// ----------------------------------------------------------------------------
package brb_pkg;

    // field widths fixed by the item format
    localparam int CAP_W  = 10;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;
    localparam int KIND_W = 2;

    // default sizing
    localparam int BRB_STORE_DEPTH = 1024;
    localparam int BRB_MAX_OP_LEN  = 64;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 10'd1023;

    // operation carried by an input item
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_START = 2'd0,
        KIND_PUSH_DATA  = 2'd1,
        KIND_POP        = 2'd2,
        KIND_DISCARD    = 2'd3
    } kind_t;

    // status of a result item
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_BUSY    = 2'd2
    } status_t;

    // what the result register is loaded with
    typedef enum logic [1:0] {
        RES_HELD     = 2'd0,
        RES_HELD_INC = 2'd1,
        RES_POP      = 2'd2,
        RES_DROP     = 2'd3
    } res_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     rd_adv;       // read store at head, advance head
        logic     push_wr;      // write byte at tail, advance tail
        logic     set_pending;  // open a push of the item length
        logic     discard;      // drop bytes from head
        logic     res_load;     // load the result register
        res_sel_t res_sel;
        status_t  res_status;
        logic     res_last;
    } brb_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pending_nz;   // a push is unfinished
        logic push_ok;      // push start length fits
        logic pop_ok;       // pop length is held
        logic slot_free;    // result register can take a result now
    } brb_sts_t;

endpackage

[hdl/brb_in_if.sv]
// ----------------------------------------------------------------------------
// brb_in_if
// Request channel: operation items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brb_in_if
    import brb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output length, output data_byte,
                    input ready);
    modport sink   (input valid, input kind, input length, input data_byte,
                    output ready);
endinterface

[hdl/brb_out_if.sv]
// ----------------------------------------------------------------------------
// brb_out_if
// Response channel: result items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface brb_out_if
    import brb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] out_byte;
    logic [CAP_W-1:0]  amount;
    logic              last;

    modport source (output valid, output status, output out_byte, output amount,
                    output last, input ready);
    modport sink   (input valid, input status, input out_byte, input amount,
                    input last, output ready);
endinterface

[hdl/brb_ram.sv]
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hdl/brb_datapath.sv]
// ----------------------------------------------------------------------------
// brb_datapath
// Ring pointers, pending push count, capacity register, byte store and the
// result register, driven by commands from the controller.
// ----------------------------------------------------------------------------
module brb_datapath
    import brb_pkg::*;
#(
    parameter int STORE_DEPTH = BRB_STORE_DEPTH,
    parameter int MAX_OP_LEN  = BRB_MAX_OP_LEN
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    input  logic [LEN_W-1:0]  length,
    input  logic [BYTE_W-1:0] data_byte,
    input  brb_cmd_t          cmd,
    output brb_sts_t          sts,
    brb_out_if.source         rsp
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = ((AW > CAP_W) ? AW : CAP_W) + 1;

    logic [CAP_W-1:0]  capacity_reg;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [LEN_W-1:0]  pending_reg, pending_next;

    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [CAP_W-1:0]  out_amount_reg;
    logic              out_last_reg;

    logic [LW-1:0]     cap_plus;
    logic [LW-1:0]     ring_len;
    logic [LW-1:0]     head_ext, tail_ext;
    logic [LW-1:0]     used;
    logic [LW-1:0]     room;
    logic [LW-1:0]     len_ext;
    logic [LW-1:0]     drop;
    logic [LW-1:0]     head_inc, tail_inc;
    logic [LW-1:0]     head_sum;
    logic [AW-1:0]     head_adv, tail_adv, head_drop;
    logic              len_bad;
    logic [BYTE_W-1:0] rd_byte;
    logic [LW-1:0]     res_amount;

    // ring length saturates at the store depth
    assign cap_plus = LW'(capacity_reg) + LW'(1);
    assign ring_len = (cap_plus > LW'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : cap_plus;

    // fill level and free space
    assign head_ext = LW'(head_reg);
    assign tail_ext = LW'(tail_reg);
    assign used     = (tail_ext >= head_ext) ? (tail_ext - head_ext)
                                             : (ring_len - (head_ext - tail_ext));
    assign room     = ring_len - LW'(1) - used;

    // request length checks
    assign len_ext = LW'(length);
    assign len_bad = (length == '0) || (length > LEN_W'(MAX_OP_LEN));

    // single-step pointer advance with wrap
    assign head_inc = head_ext + LW'(1);
    assign tail_inc = tail_ext + LW'(1);
    assign head_adv = (head_inc >= ring_len) ? '0 : AW'(head_inc);
    assign tail_adv = (tail_inc >= ring_len) ? '0 : AW'(tail_inc);

    // discard: clamp and move head by the dropped count
    assign drop      = (len_ext < used) ? len_ext : used;
    assign head_sum  = head_ext + drop;
    assign head_drop = (head_sum >= ring_len) ? AW'(head_sum - ring_len) : AW'(head_sum);

    // status to controller
    assign sts.pending_nz = (pending_reg != '0);
    assign sts.push_ok    = !len_bad && (len_ext <= room);
    assign sts.pop_ok     = !len_bad && (len_ext <= used);
    assign sts.slot_free  = !out_valid_reg || rsp.ready;

    // pointer and pending updates
    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        pending_next = pending_reg;
        if (cmd.rd_adv)
        begin
            head_next = head_adv;
        end
        if (cmd.push_wr)
        begin
            tail_next    = tail_adv;
            pending_next = pending_reg - LEN_W'(1);
        end
        if (cmd.set_pending)
        begin
            pending_next = length;
        end
        if (cmd.discard)
        begin
            if (head_drop == tail_reg)
            begin
                head_next = '0;
                tail_next = '0;
            end
            else
            begin
                head_next = head_drop;
            end
        end
        if (cfg_we)
        begin
            head_next    = '0;
            tail_next    = '0;
            pending_next = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            pending_reg <= pending_next;
        end
    end

    // byte store
    brb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push_wr),
        .waddr (tail_reg),
        .wdata (data_byte),
        .re    (cmd.rd_adv),
        .raddr (head_reg),
        .rdata (rd_byte)
    );

    // result amount select
    always_comb
    begin
        case (cmd.res_sel)
            RES_HELD_INC: res_amount = used + LW'(1);
            RES_DROP:     res_amount = drop;
            default:      res_amount = used;
        endcase
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_status_reg <= cmd.res_status;
            out_byte_reg   <= (cmd.res_sel == RES_POP) ? rd_byte : '0;
            out_amount_reg <= CAP_W'(res_amount);
            out_last_reg   <= cmd.res_last;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.out_byte = out_byte_reg;
    assign rsp.amount   = out_amount_reg;
    assign rsp.last     = out_last_reg;

endmodule

[hdl/brb_controller.sv]
// ----------------------------------------------------------------------------
// brb_controller
// Decodes request items, sequences pops byte by byte and issues datapath
// commands.
// ----------------------------------------------------------------------------
module brb_controller
    import brb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [KIND_W-1:0] kind,
    input  logic [LEN_W-1:0]  length,
    output logic              req_ready,
    input  brb_sts_t          sts,
    output brb_cmd_t          cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [LEN_W-1:0] count_reg, count_next;
    logic             accept;

    assign req_ready = (state_reg == S_IDLE) && sts.slot_free;
    assign accept    = req_valid && req_ready;

    // command decode and sequencing
    always_comb
    begin
        cmd            = '0;
        cmd.res_sel    = RES_HELD;
        cmd.res_status = ST_OK;
        cmd.res_last   = 1'b1;
        state_next     = state_reg;
        count_next     = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (kind_t'(kind) == KIND_PUSH_DATA)
                    begin
                        cmd.res_load = 1'b1;
                        if (sts.pending_nz)
                        begin
                            cmd.push_wr = 1'b1;
                            cmd.res_sel = RES_HELD_INC;
                        end
                        else
                        begin
                            cmd.res_status = ST_REFUSED;
                        end
                    end
                    else if (sts.pending_nz)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_BUSY;
                    end
                    else
                    begin
                        case (kind_t'(kind))
                            KIND_PUSH_START:
                            begin
                                cmd.res_load = 1'b1;
                                if (sts.push_ok)
                                begin
                                    cmd.set_pending = 1'b1;
                                end
                                else
                                begin
                                    cmd.res_status = ST_REFUSED;
                                end
                            end
                            KIND_POP:
                            begin
                                if (sts.pop_ok)
                                begin
                                    count_next = length;
                                    state_next = S_POP_RD;
                                end
                                else
                                begin
                                    cmd.res_load   = 1'b1;
                                    cmd.res_status = ST_REFUSED;
                                end
                            end
                            default:
                            begin
                                cmd.discard  = 1'b1;
                                cmd.res_load = 1'b1;
                                cmd.res_sel  = RES_DROP;
                            end
                        endcase
                    end
                end
            end
            S_POP_RD:
            begin
                // first read of a pop
                cmd.rd_adv = 1'b1;
                count_next = count_reg - LEN_W'(1);
                state_next = S_POP_OUT;
            end
            S_POP_OUT:
            begin
                // when the result slot is free, emit one byte and fetch the next in the same cycle
                if (sts.slot_free)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_POP;
                    cmd.res_last = (count_reg == '0);
                    if (count_reg != '0)
                    begin
                        cmd.rd_adv = 1'b1;
                        count_next = count_reg - LEN_W'(1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

[hdl/byte_ring_buffer.sv]
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Circular byte buffer with whole-or-nothing pushes and pops and clamped discards.
//
//   channel  direction  handshake     payload
//   req      in         valid/ready   kind, length, data_byte
//   rsp      out        valid/ready   status, out_byte, amount, last
//   cfg      in         cfg_we        cfg_wdata (capacity)
//
// Push start, push data, discard and refused items each give one result. A
// good pop of n bytes is accepted, then the first store read is made, then
// the bytes come out one byte per cycle through the registered read port
// while rsp takes them. No item is taken while a pop runs. A stalled rsp holds
// the result register and the request side waits only for that one slot. Reset
// clears the pointers and sets capacity to 1023; the store is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int STORE_DEPTH = BRB_STORE_DEPTH,
    parameter int MAX_OP_LEN  = BRB_MAX_OP_LEN
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    brb_in_if.sink           req,
    brb_out_if.source        rsp
);

    brb_cmd_t cmd;
    brb_sts_t sts;

    // sequencing
    brb_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .kind      (req.kind),
        .length    (req.length),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and result
    brb_datapath #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_OP_LEN  (MAX_OP_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .length    (req.length),
        .data_byte (req.data_byte),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp)
    );

endmodule
